### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define JTCW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("jtcw check failed");

// clocked property that must hold during reset too
`define JTCW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("jtcw check failed");

`endif

### src/jtcw_pkg.sv
// shared constants and command type for the json token child walker
`default_nettype none

package jtcw_pkg;

  // opcodes carried on the slave tuser
  localparam logic [2:0] OP_LOAD      = 3'd0;
  localparam logic [2:0] OP_ARR_COUNT = 3'd1;
  localparam logic [2:0] OP_ARR_NTH   = 3'd2;
  localparam logic [2:0] OP_OBJ_COUNT = 3'd3;
  localparam logic [2:0] OP_OBJ_KEY   = 3'd4;
  localparam logic [2:0] OP_OBJ_VALUE = 3'd5;

  // field widths
  localparam int OP_W     = 3;
  localparam int SLOT_W   = 7;
  localparam int SPAN_W   = 16;
  localparam int NTH_W    = 7;
  localparam int ANSWER_W = 9;
  localparam int COUNT_W  = 8;

  // stream data widths, padded to whole bytes
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 16;

  // config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // answer for a missing child
  localparam logic [ANSWER_W-1:0] ANSWER_MISS = 9'h1FF;

  // decoded command passed from front to back
  typedef struct packed {
    logic                is_load;
    logic                is_obj;
    logic                want_nth;
    logic                val_off;
    logic [SLOT_W-1:0]   slot;
    logic [SPAN_W-1:0]   span_start;
    logic [SPAN_W-1:0]   span_end;
    logic [NTH_W-1:0]    nth;
  } cmd_t;

endpackage

`default_nettype wire

### src/jtcw_front.sv
// front end: takes input transfers, decodes the opcode, queues commands
`default_nettype none

module jtcw_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: token_slot[6:0], span_start[22:7], span_end[38:23],
  //        element_number[45:39], zero[47:46]
  input  wire logic [jtcw_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: opcode[2:0]
  input  wire logic [jtcw_pkg::OP_W-1:0]      s_axis_tuser,
  output jtcw_pkg::cmd_t                      cmd_o,
  output logic                                cmd_valid_o,
  input  wire logic                           cmd_ready_i
);
  import jtcw_pkg::*;

  localparam int DEPTH = 2;

  cmd_t             cmd_in;
  logic             keep;
  logic             push, pop;
  cmd_t             q_mem [DEPTH];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;

  // unpack payload and classify the opcode
  always_comb begin
    cmd_in            = '0;
    cmd_in.slot       = s_axis_tdata[6:0];
    cmd_in.span_start = s_axis_tdata[22:7];
    cmd_in.span_end   = s_axis_tdata[38:23];
    cmd_in.nth        = s_axis_tdata[45:39];
    keep              = 1'b1;
    unique case (s_axis_tuser)
      OP_LOAD: begin
        cmd_in.is_load = 1'b1;
      end
      OP_ARR_COUNT: begin
      end
      OP_ARR_NTH: begin
        cmd_in.want_nth = 1'b1;
      end
      OP_OBJ_COUNT: begin
        cmd_in.is_obj = 1'b1;
      end
      OP_OBJ_KEY: begin
        cmd_in.is_obj   = 1'b1;
        cmd_in.want_nth = 1'b1;
      end
      OP_OBJ_VALUE: begin
        cmd_in.is_obj   = 1'b1;
        cmd_in.want_nth = 1'b1;
        cmd_in.val_off  = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // queue handshake
  assign s_axis_tready = (fill_q != 2'(DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready && keep;
  assign cmd_valid_o   = (fill_q != 2'd0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = q_mem[rd_ptr_q];

  // pointer and fill update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

### src/jtcw_back.sv
// back end: span tables, child walk sequencer and output register
`default_nettype none

module jtcw_back #(
  parameter int TOKENS = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  jtcw_pkg::cmd_t                      cmd_i,
  input  wire logic                           cmd_valid_i,
  output logic                                cmd_ready_o,
  input  wire logic [jtcw_pkg::COUNT_W-1:0]   token_count_i,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: answer[8:0], zero[15:9]
  output logic [jtcw_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
  import jtcw_pkg::*;

  localparam int AW = (TOKENS > 1) ? $clog2(TOKENS) : 1;
  localparam int NW = ($clog2(TOKENS + 1) > COUNT_W) ? $clog2(TOKENS + 1) : COUNT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PARENT = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [SPAN_W-1:0]   start_mem [TOKENS];
  logic [SPAN_W-1:0]   end_mem   [TOKENS];
  logic [SPAN_W-1:0]   rd_start_q, rd_end_q;

  logic [1:0]          state_q, state_d;
  logic [NW-1:0]       cur_q, cur_d;
  logic [NW-1:0]       found_q, found_d;
  logic [SPAN_W-1:0]   limit_q, limit_d;
  logic [SPAN_W-1:0]   pend_q, pend_d;
  logic [ANSWER_W-1:0] ans_q, ans_d;
  logic                is_obj_q, is_obj_d;
  logic                want_nth_q, want_nth_d;
  logic                val_off_q, val_off_d;
  logic [NTH_W-1:0]    nth_q, nth_d;
  logic                out_valid_q, out_valid_d;
  logic [ANSWER_W-1:0] out_data_q, out_data_d;

  logic [NW-1:0]       tc_ext, live_n, parent_ext;
  logic [NW:0]         cur_inc;
  logic [NW-1:0]       rd_idx, rd_end_idx;
  logic                wr_en, out_free;
  logic [ANSWER_W-1:0] miss_ans;

  // live token count, capped at the table depth
  assign tc_ext     = NW'(token_count_i);
  assign live_n     = (tc_ext > NW'(TOKENS)) ? NW'(TOKENS) : tc_ext;
  assign parent_ext = NW'(cmd_i.slot);
  assign cur_inc    = {1'b0, cur_q} + (NW + 1)'(1);

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || m_axis_tready;
  assign wr_en       = cmd_valid_i && cmd_ready_o && cmd_i.is_load &&
                       (parent_ext < NW'(TOKENS));
  assign miss_ans    = want_nth_q ? ANSWER_MISS : ANSWER_W'(found_q);

  // table read addresses: parent first, then one walk position per cycle
  always_comb begin
    unique case (state_q)
      ST_IDLE:   rd_idx = parent_ext;
      ST_PARENT: rd_idx = cur_q;
      default:   rd_idx = NW'(cur_inc);
    endcase
    rd_end_idx = (state_q != ST_IDLE && is_obj_q) ? rd_idx + NW'(1) : rd_idx;
  end

  // span tables, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[AW'(cmd_i.slot)] <= cmd_i.span_start;
      end_mem[AW'(cmd_i.slot)]   <= cmd_i.span_end;
    end
    rd_start_q <= start_mem[AW'(rd_idx)];
    rd_end_q   <= end_mem[AW'(rd_end_idx)];
  end

  // walk sequencer
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    found_d     = found_q;
    limit_d     = limit_q;
    pend_d      = pend_q;
    ans_d       = ans_q;
    is_obj_d    = is_obj_q;
    want_nth_d  = want_nth_q;
    val_off_d   = val_off_q;
    nth_d       = nth_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !cmd_i.is_load) begin
          is_obj_d   = cmd_i.is_obj;
          want_nth_d = cmd_i.want_nth;
          val_off_d  = cmd_i.val_off;
          nth_d      = cmd_i.nth;
          cur_d      = parent_ext + NW'(1);
          found_d    = '0;
          if (parent_ext >= live_n) begin
            ans_d   = cmd_i.want_nth ? ANSWER_MISS : '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_PARENT;
          end
        end
      end
      ST_PARENT: begin
        limit_d = rd_start_q;
        pend_d  = rd_end_q;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (cur_q >= live_n || rd_start_q > pend_q) begin
          ans_d   = miss_ans;
          state_d = ST_DONE;
        end else if (rd_start_q <= limit_q) begin
          cur_d = NW'(cur_inc);
        end else if (is_obj_q && cur_inc >= {1'b0, live_n}) begin
          // trailing key with no value inside the count
          ans_d   = miss_ans;
          state_d = ST_DONE;
        end else begin
          limit_d = rd_end_q;
          if (want_nth_q && found_q == NW'(nth_q)) begin
            ans_d   = val_off_q ? ANSWER_W'(cur_inc) : ANSWER_W'(cur_q);
            state_d = ST_DONE;
          end else begin
            found_d = found_q + NW'(1);
            cur_d   = NW'(cur_inc);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = ans_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // walk payload
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    found_q    <= found_d;
    limit_q    <= limit_d;
    pend_q     <= pend_d;
    ans_q      <= ans_d;
    is_obj_q   <= is_obj_d;
    want_nth_q <= want_nth_d;
    val_off_q  <= val_off_d;
    nth_q      <= nth_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_data_q);

endmodule

`default_nettype wire

### src/json_token_child_walker_top.sv
// Order: a load writes its span entries as it leaves the queue; a query goes from ST_IDLE
// to ST_PARENT (parent read), then ST_WALK, reading one table entry per cycle past the
// parent until the answer is known, then ST_DONE, which waits for the output register to
// be free; a bad parent goes from ST_IDLE straight to ST_DONE. Throughput: one item at
// a time; no new command is taken until ST_DONE passes the answer on.
// Reset: clears queue, sequencer, output valid and token_count; span tables stay unknown
`default_nettype none

module json_token_child_walker_top #(
  parameter int TOKENS = 128
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: token_slot[6:0], span_start[22:7], span_end[38:23],
  //        element_number[45:39], zero[47:46]
  input  wire logic [jtcw_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: opcode[2:0]
  input  wire logic [jtcw_pkg::OP_W-1:0]      s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: answer[8:0], zero[15:9]
  output logic [jtcw_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // config port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [jtcw_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [jtcw_pkg::PDATA_W-1:0]   pwdata,
  output logic [jtcw_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import jtcw_pkg::*;

  cmd_t               cmd;
  logic               cmd_valid, cmd_ready;
  logic [COUNT_W-1:0] token_count_q;
  logic               reg_sel;

  // token_count register at byte address 0
  assign pready  = 1'b1;
  assign reg_sel = !paddr[2];
  assign prdata  = reg_sel ? PDATA_W'(token_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_count_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      token_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  jtcw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_o         (cmd),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready)
  );

  jtcw_back #(
    .TOKENS (TOKENS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .token_count_i (token_count_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### src/jtcw_checker.sv
// port-level checks for the json token child walker, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module jtcw_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [jtcw_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic [jtcw_pkg::PADDR_W-1:0]   paddr,
  input wire logic [jtcw_pkg::PDATA_W-1:0]   pwdata,
  input wire logic [jtcw_pkg::PDATA_W-1:0]   prdata,
  input wire logic                           pready
);

  // a stalled result keeps its valid and its data
  `JTCW_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `JTCW_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))

  // answer padding bits stay zero
  `JTCW_ASSERT(a_out_pad, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)

  // config port never waits
  `JTCW_ASSERT_ALWAYS(a_pready, clk_i, pready)

  // a token_count write reads back on the next cycle
  `JTCW_ASSERT(a_count_readback, clk_i, rst_ni, psel && penable && pwrite && !paddr[2] |=> (!(psel && !pwrite && !paddr[2]) || prdata[7:0] == $past(pwdata[7:0])))

endmodule

bind json_token_child_walker_top jtcw_checker u_jtcw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);

`default_nettype wire
